// ----- design/tlu_pkg.sv -----
// Shared types and constants of the taint label engine.
package tlu_pkg;

  localparam int unsigned LBITS = 16;
  localparam int unsigned SBITS = 8;
  localparam int unsigned DBITS = 16;
  localparam int unsigned CNTW  = LBITS + 1;
  localparam logic [CNTW-1:0] PROBE_LAST = {1'b0, {LBITS{1'b1}}};

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_UNION  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  localparam logic REG_INITIAL_DECAY = 1'b0;
  localparam logic REG_UNION_BASE    = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CREATE,
    OP_CREATE_OVF,
    OP_PASS,
    OP_UNION
  } op_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [LBITS-1:0] first_label;
    logic [LBITS-1:0] second_label;
    logic [LBITS-1:0] canonical_offset;
    logic [SBITS-1:0] source_mask;
  } in_t;

  typedef struct packed {
    logic [LBITS-1:0] result_label;
    logic             newly_made;
    logic             status;
    logic [LBITS-1:0] top_union_label;
  } out_t;

  typedef struct packed {
    op_t              op;
    logic [LBITS-1:0] label;
    logic [LBITS-1:0] lo;
    logic [LBITS-1:0] hi;
    logic [LBITS-1:0] hash;
    logic [SBITS-1:0] src;
  } qitem_t;

  typedef struct packed {
    logic [LBITS-1:0] par_a;
    logic [LBITS-1:0] par_b;
    logic [SBITS-1:0] src;
    logic [DBITS-1:0] decay;
  } node_t;

  typedef struct packed {
    logic             valid;
    logic [LBITS-1:0] lo;
    logic [LBITS-1:0] hi;
  } memo_t;

  typedef struct packed {
    logic             used;
    logic [LBITS-1:0] lo;
    logic [LBITS-1:0] hi;
    logic [LBITS-1:0] lab;
  } hent_t;

  typedef struct packed {
    logic [DBITS-1:0] initial_decay;
    logic             base_we;
    logic [LBITS-1:0] base;
  } cfg_t;

endpackage

// ----- design/tlu_front.sv -----
// Request classifier: orders union operands and computes the pair hash.
module tlu_front (
  input  tlu_pkg::in_t    req,
  output tlu_pkg::qitem_t item
);

  logic [tlu_pkg::LBITS:0] create_lab;

  always_comb begin
    create_lab = {1'b0, req.canonical_offset} + {{tlu_pkg::LBITS{1'b0}}, 1'b1};
    item       = '0;
    item.op    = tlu_pkg::OP_NOP;
    item.src   = req.source_mask;
    case (req.req_type)
      tlu_pkg::REQ_CREATE: begin
        item.label = create_lab[tlu_pkg::LBITS-1:0];
        item.op    = create_lab[tlu_pkg::LBITS] ? tlu_pkg::OP_CREATE_OVF : tlu_pkg::OP_CREATE;
      end
      tlu_pkg::REQ_UNION: begin
        if (req.first_label == '0) begin
          item.op    = tlu_pkg::OP_PASS;
          item.label = req.second_label;
        end else if (req.second_label == '0) begin
          item.op    = tlu_pkg::OP_PASS;
          item.label = req.first_label;
        end else begin
          item.op = tlu_pkg::OP_UNION;
          if (req.first_label < req.second_label) begin
            item.lo = req.first_label;
            item.hi = req.second_label;
          end else begin
            item.lo = req.second_label;
            item.hi = req.first_label;
          end
          item.hash = item.lo ^ {item.hi[tlu_pkg::LBITS/2-1:0],
                                 item.hi[tlu_pkg::LBITS-1:tlu_pkg::LBITS/2]};
        end
      end
      default: item.op = tlu_pkg::OP_NOP;
    endcase
  end

endmodule

// ----- design/tlu_queue.sv -----
// Two-entry queue between the classifier and the engine.
module tlu_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tlu_pkg::qitem_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output tlu_pkg::qitem_t head
);

  tlu_pkg::qitem_t slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rp_r];

endmodule

// ----- design/tlu_back.sv -----
// Label engine: node store, pair memo, hash index, union counter and result register.
module tlu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tlu_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  tlu_pkg::qitem_t q_item,
  output logic            q_pop,
  output logic            clearing,
  output logic            out_valid,
  input  logic            out_stall,
  output tlu_pkg::out_t   out_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HRD, S_HCHK, S_MCHK, S_RDA, S_RDB, S_CALC, S_FIN
  } state_t;

  localparam int unsigned LB = tlu_pkg::LBITS;

  state_t state_r, state_nxt;
  tlu_pkg::qitem_t item_r, item_nxt;
  logic [LB-1:0] probe_r, probe_nxt, free_r, free_nxt, clr_r, clr_nxt;
  logic [LB-1:0] cnt_r, cnt_nxt, res_r, res_nxt;
  logic [tlu_pkg::CNTW-1:0] pcnt_r, pcnt_nxt;
  logic free_found_r, free_found_nxt, made_r, made_nxt, st_r, st_nxt;
  logic out_valid_r, out_valid_nxt;
  tlu_pkg::out_t out_data_r, out_data_nxt;
  tlu_pkg::node_t na_r, na_nxt;

  tlu_pkg::node_t node_mem [2**LB];
  tlu_pkg::memo_t memo_mem [2**LB];
  tlu_pkg::hent_t hash_mem [2**LB];
  tlu_pkg::node_t node_q, node_wdata;
  tlu_pkg::memo_t memo_q, memo_wdata;
  tlu_pkg::hent_t hash_q, hash_wdata;
  logic node_we, memo_we, hash_we;
  logic [LB-1:0] node_waddr, node_raddr, memo_waddr, memo_raddr, hash_waddr, hash_raddr;

  logic [tlu_pkg::DBITS:0] dsum;
  logic [tlu_pkg::DBITS-1:0] dec;
  logic live, out_load;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    probe_nxt      = probe_r;
    free_nxt       = free_r;
    free_found_nxt = free_found_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    made_nxt       = made_r;
    st_nxt         = st_r;
    pcnt_nxt       = pcnt_r;
    na_nxt         = na_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_load       = 1'b0;
    q_pop          = 1'b0;
    node_we = 1'b0; memo_we = 1'b0; hash_we = 1'b0;
    node_waddr = clr_r; memo_waddr = clr_r; hash_waddr = clr_r;
    node_wdata = '0; memo_wdata = '0; hash_wdata = '0;
    node_raddr = item_r.lo;
    memo_raddr = hash_q.lab;
    hash_raddr = probe_r;
    live  = memo_q.valid && memo_q.lo == hash_q.lo && memo_q.hi == hash_q.hi;
    dsum  = {1'b0, na_r.decay} + {1'b0, node_q.decay};
    dec   = {1'b0, dsum[tlu_pkg::DBITS:2]};

    case (state_r)
      S_CLEAR: begin
        node_we = 1'b1;
        memo_we = 1'b1;
        hash_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          res_nxt  = '0;
          made_nxt = 1'b0;
          st_nxt   = 1'b0;
          state_nxt = S_FIN;
          case (q_item.op)
            tlu_pkg::OP_CREATE: begin
              node_we    = 1'b1;
              node_waddr = q_item.label;
              node_wdata = '{par_a: '0, par_b: '0, src: q_item.src,
                             decay: cfg.initial_decay};
              res_nxt    = q_item.label;
              made_nxt   = 1'b1;
            end
            tlu_pkg::OP_CREATE_OVF: st_nxt = 1'b1;
            tlu_pkg::OP_PASS:       res_nxt = q_item.label;
            tlu_pkg::OP_UNION: begin
              probe_nxt      = q_item.hash;
              pcnt_nxt       = '0;
              free_found_nxt = 1'b0;
              state_nxt      = S_HRD;
            end
            default: res_nxt = '0;
          endcase
        end
      end
      S_HRD: state_nxt = S_HCHK;
      S_HCHK: begin
        if (!hash_q.used) begin
          free_nxt  = free_found_r ? free_r : probe_r;
          state_nxt = S_RDA;
        end else begin
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (live && hash_q.lo == item_r.lo && hash_q.hi == item_r.hi) begin
          res_nxt   = hash_q.lab;
          state_nxt = S_FIN;
        end else begin
          if (!live && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = probe_r;
          end
          if (pcnt_r == tlu_pkg::PROBE_LAST) begin
            state_nxt = S_RDA;
          end else begin
            probe_nxt = probe_r + 1'b1;
            pcnt_nxt  = pcnt_r + 1'b1;
            state_nxt = S_HRD;
          end
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        node_raddr = item_r.hi;
        na_nxt     = node_q;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        state_nxt = S_FIN;
        if (dec == '0) begin
          res_nxt = '0;
        end else if (cnt_r == '1) begin
          st_nxt = 1'b1;
        end else begin
          cnt_nxt    = cnt_r + 1'b1;
          node_we    = 1'b1;
          node_waddr = cnt_nxt;
          node_wdata = '{par_a: item_r.lo, par_b: item_r.hi,
                         src: na_r.src | node_q.src, decay: dec};
          memo_we    = 1'b1;
          memo_waddr = cnt_nxt;
          memo_wdata = '{valid: 1'b1, lo: item_r.lo, hi: item_r.hi};
          hash_we    = 1'b1;
          hash_waddr = free_r;
          hash_wdata = '{used: 1'b1, lo: item_r.lo, hi: item_r.hi, lab: cnt_nxt};
          res_nxt    = cnt_nxt;
          made_nxt   = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_label: res_r, newly_made: made_r, status: st_r,
                            top_union_label: cnt_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg.base_we) begin
      cnt_nxt = cfg.base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pcnt_r      <= pcnt_nxt;
    end
    item_r       <= item_nxt;
    probe_r      <= probe_nxt;
    free_r       <= free_nxt;
    free_found_r <= free_found_nxt;
    res_r        <= res_nxt;
    made_r       <= made_nxt;
    st_r         <= st_nxt;
    na_r         <= na_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (memo_we) begin
      memo_mem[memo_waddr] <= memo_wdata;
    end
    memo_q <= memo_mem[memo_raddr];
  end

  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[hash_waddr] <= hash_wdata;
    end
    hash_q <= hash_mem[hash_raddr];
  end

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !q_pop)
    else $error("Queue popped during the clearing pass.");

  a_made_not_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(made_r && st_r))
    else $error("Result both made a node and was refused.");

  a_alloc_steps_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC && made_nxt && !cfg.base_we) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("Union counter did not advance by one on allocation.");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && q_valid))
    else $error("Queue popped outside the idle state.");

endmodule

// ----- design/taint_label_union.sv -----
// Top level of the taint label engine with its register port.
// After reset the engine clears its node store, pair memo and hash index in a pass over
// every entry, during which in_stall is high; register writes are taken throughout.
// Requests enter a two-entry queue and are carried out one at a time by the engine.
// A union probes the hash index from the pair hash until it finds the pair memoized,
// meets an empty entry, or has probed every entry; if the pair is not memoized, it then
// reads both operand nodes and may allocate a new union label.
// A finished result waits in an output register while the next request is already
// being worked on.
module taint_label_union (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tlu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tlu_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  tlu_pkg::qitem_t item, head;
  tlu_pkg::cfg_t   cfg;
  logic q_full, q_valid, q_pop, clearing, push, wr;
  logic [tlu_pkg::DBITS-1:0] decay_r, decay_nxt;
  logic [tlu_pkg::LBITS-1:0] base_r, base_nxt;

  assign wr        = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign decay_nxt = (wr && paddr[2] == tlu_pkg::REG_INITIAL_DECAY) ?
                     pwdata[tlu_pkg::DBITS-1:0] : decay_r;
  assign base_nxt  = (wr && paddr[2] == tlu_pkg::REG_UNION_BASE) ?
                     pwdata[tlu_pkg::LBITS-1:0] : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= tlu_pkg::DBITS'(16);
      base_r  <= '0;
    end else begin
      decay_r <= decay_nxt;
      base_r  <= base_nxt;
    end
  end

  assign prdata = (paddr[2] == tlu_pkg::REG_UNION_BASE) ?
                  {{(32-tlu_pkg::LBITS){1'b0}}, base_r} :
                  {{(32-tlu_pkg::DBITS){1'b0}}, decay_r};

  assign cfg.initial_decay = decay_r;
  assign cfg.base_we       = wr && paddr[2] == tlu_pkg::REG_UNION_BASE;
  assign cfg.base          = pwdata[tlu_pkg::LBITS-1:0];

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  tlu_front u_front (
    .req  (in_data),
    .item (item)
  );

  tlu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  tlu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- bench/taint_label_union_tb.sv -----
// Self-checking testbench of the taint label engine with directed and random requests.
`timescale 1ns / 100ps

class label_scoreboard;
  tlu_pkg::node_t nodes[int unsigned];
  logic [47:0]    pair_memo[int unsigned];
  logic [15:0]    union_counter;
  logic [15:0]    initial_decay;
  tlu_pkg::out_t  pending_results[$];
  int             errors;
  int             made_count;
  int             overflow_count;

  function new();
    union_counter = 16'd0;
    initial_decay = 16'd16;
    errors = 0;
    made_count = 0;
    overflow_count = 0;
  endfunction

  function void write_reg(bit is_base, logic [15:0] value);
    if (is_base) union_counter = value;
    else initial_decay = value;
  endfunction

  function tlu_pkg::node_t node_at(logic [15:0] label);
    tlu_pkg::node_t n;
    n = '0;
    if (nodes.exists(label)) n = nodes[label];
    return n;
  endfunction

  function void note_request(tlu_pkg::in_t req);
    tlu_pkg::out_t  r;
    tlu_pkg::node_t na, nb, nn;
    logic [15:0]    a, b;
    logic [17:0]    dsum;
    logic [15:0]    dec;
    bit             hit;
    int unsigned    slot;
    r = '0;
    if (req.req_type == tlu_pkg::REQ_CREATE) begin
      if (req.canonical_offset == 16'hffff) begin
        r.status = 1'b1;
      end else begin
        nn = '0;
        nn.src = req.source_mask;
        nn.decay = initial_decay;
        nodes[req.canonical_offset + 16'd1] = nn;
        r.result_label = req.canonical_offset + 16'd1;
        r.newly_made = 1'b1;
      end
    end else if (req.req_type == tlu_pkg::REQ_UNION) begin
      if (req.first_label == 0) begin
        r.result_label = req.second_label;
      end else if (req.second_label == 0) begin
        r.result_label = req.first_label;
      end else begin
        a = (req.first_label < req.second_label) ? req.first_label : req.second_label;
        b = (req.first_label < req.second_label) ? req.second_label : req.first_label;
        hit = 0;
        foreach (pair_memo[k]) begin
          if (!hit && pair_memo[k][47:32] == a && pair_memo[k][31:16] == b) begin
            hit = 1;
            r.result_label = pair_memo[k][15:0];
          end
        end
        if (!hit) begin
          na = node_at(a);
          nb = node_at(b);
          dsum = na.decay + nb.decay;
          dec = dsum >> 2;
          if (dec == 0) begin
            r.result_label = 16'd0;
          end else if (union_counter == 16'hffff) begin
            r.status = 1'b1;
          end else begin
            union_counter = union_counter + 16'd1;
            slot = union_counter;
            nn.par_a = a;
            nn.par_b = b;
            nn.src = na.src | nb.src;
            nn.decay = dec;
            nodes[slot] = nn;
            pair_memo[slot] = {a, b, union_counter};
            r.result_label = union_counter;
            r.newly_made = 1'b1;
          end
        end
      end
    end
    r.top_union_label = union_counter;
    made_count += r.newly_made;
    overflow_count += r.status;
    pending_results = {pending_results, r};
  endfunction

  function void check_result(tlu_pkg::out_t got);
    tlu_pkg::out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.result_label !== want.result_label) begin
      $display("%0t: result_label expected %h actual %h", $time, want.result_label,
               got.result_label);
      errors++;
    end
    if (got.newly_made !== want.newly_made) begin
      $display("%0t: newly_made expected %b actual %b", $time, want.newly_made, got.newly_made);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %b actual %b", $time, want.status, got.status);
      errors++;
    end
    if (got.top_union_label !== want.top_union_label) begin
      $display("%0t: top_union_label expected %h actual %h", $time, want.top_union_label,
               got.top_union_label);
      errors++;
    end
  endfunction
endclass

module taint_label_union_tb;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  tlu_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  tlu_pkg::out_t out_data;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  label_scoreboard sb;
  int          cycle_count;
  int          results_seen;
  int          requests_sent;
  bit          hold_off;
  logic [15:0] live_labels[$];

  localparam int CYCLE_LIMIT = 2000000;

  taint_label_union i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("taint_label_union test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results_seen <= results_seen + 1;
    end
  end

  initial begin
    int run_len;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      run_len = $urandom_range(1, 20);
      case ($urandom_range(0, 3))
        0: out_stall <= 1'b0;
        1: out_stall <= 1'b1;
        default: out_stall <= ($urandom_range(0, 2) == 0);
      endcase
      repeat (run_len) @(posedge clk);
    end
  end

  task automatic write_reg(bit is_base, logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {(is_base ? tlu_pkg::REG_UNION_BASE : tlu_pkg::REG_INITIAL_DECAY), 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    sb.write_reg(is_base, value);
  endtask

  task automatic send_request(tlu_pkg::in_t req);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    requests_sent++;
    if (req.req_type == tlu_pkg::REQ_CREATE && req.canonical_offset != 16'hffff)
      live_labels = {live_labels, 16'(req.canonical_offset + 16'd1)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic tlu_pkg::in_t make_req(logic [1:0] rt, logic [15:0] l1,
                                            logic [15:0] l2, logic [15:0] off,
                                            logic [7:0] src);
    tlu_pkg::in_t r;
    r.req_type = rt;
    r.first_label = l1;
    r.second_label = l2;
    r.canonical_offset = off;
    r.source_mask = src;
    return r;
  endfunction

  function automatic logic [15:0] pick_label();
    if (live_labels.size() == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
    return live_labels[$urandom_range(0, live_labels.size() - 1)];
  endfunction

  task automatic random_phase(int count);
    tlu_pkg::in_t r;
    int  k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: r = make_req(tlu_pkg::REQ_CREATE, 16'($urandom), 16'($urandom),
                              16'($urandom_range(0, 60)), 8'($urandom));
        3: r = make_req(($urandom_range(0, 1) ? tlu_pkg::REQ_QUERY : tlu_pkg::REQ_SPARE),
                        16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        4: r = make_req(tlu_pkg::REQ_UNION, ($urandom_range(0, 1) ? 16'd0 : 16'($urandom)),
                        16'($urandom), 16'($urandom), 8'($urandom));
        default: r = make_req(tlu_pkg::REQ_UNION, pick_label(), pick_label(),
                              16'($urandom), 8'($urandom));
      endcase
      send_request(r);
      if (live_labels.size() > 64) void'(live_labels.pop_front());
    end
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    results_seen = 0;
    requests_sent = 0;
    hold_off = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(make_req(tlu_pkg::REQ_UNION, 16'd1, 16'd2, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_CREATE, 16'd0, 16'd0, 16'd0, 8'h01));
    send_request(make_req(tlu_pkg::REQ_CREATE, 16'hffff, 16'hffff, 16'd1, 8'h80));
    send_request(make_req(tlu_pkg::REQ_CREATE, 16'd0, 16'd0, 16'hfffe, 8'hff));
    send_request(make_req(tlu_pkg::REQ_CREATE, 16'd0, 16'd0, 16'hffff, 8'hff));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd0, 16'd2, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'hffff, 16'd0, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd2, 16'd1, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd1, 16'd2, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd2, 16'd2, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd1, 16'hffff, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_QUERY, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    send_request(make_req(tlu_pkg::REQ_SPARE, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd100, 16'd200, 16'd0, 8'd0));
    drain();
    write_reg(1'b0, 16'd1);
    write_reg(1'b1, 16'hfffe);
    send_request(make_req(tlu_pkg::REQ_CREATE, 16'd0, 16'd0, 16'd9, 8'h0f));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd10, 16'd2, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_CREATE, 16'd0, 16'd0, 16'd10, 8'hf0));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd11, 16'd3, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd11, 16'd4, 16'd0, 8'd0));
    send_request(make_req(tlu_pkg::REQ_UNION, 16'd11, 16'd5, 16'd0, 8'd0));
    drain();

    write_reg(1'b0, 16'hffff);
    write_reg(1'b1, 16'd0);
    hold_off = 1;
    random_phase(400);
    drain();
    write_reg(1'b0, 16'd16);
    write_reg(1'b1, 16'd5000);
    random_phase(400);
    drain();
    write_reg(1'b0, 16'd3);
    write_reg(1'b1, 16'hfff0);
    random_phase(300);
    drain();

    $display("Sent %0d requests, checked %0d results, %0d new nodes, %0d refusals.",
             requests_sent, results_seen, sb.made_count, sb.overflow_count);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("taint_label_union test passed");
    end else begin
      $display("taint_label_union test failed");
    end
    $finish;
  end
endmodule
